### rtl/core/anpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AS-path NFA matcher package
// Shared sizes, instruction codes and the record types of the matcher.
// ----------------------------------------------------------------------------
package anpm_pkg;

   localparam int PROGRAM_DEPTH = 64;
   localparam int THREAD_LIST   = 32;
   localparam int MAX_GROUPS    = 8;
   localparam int MAX_RECORDS   = 8;
   localparam int NUM_RECORDS   = (MAX_GROUPS < MAX_RECORDS) ? MAX_GROUPS : MAX_RECORDS;
   localparam int CHAIN_LIMIT   = PROGRAM_DEPTH + 1;

   localparam int IDX_W   = 6;
   localparam int SLOT_W  = $clog2(THREAD_LIST);
   localparam int CNT_W   = $clog2(THREAD_LIST + 1);
   localparam int GRP_W   = $clog2(MAX_GROUPS);
   localparam int GK_W    = GRP_W + 1;
   localparam int CHAIN_W = $clog2(CHAIN_LIMIT + 1);
   localparam int PC_AW   = 1 + SLOT_W;
   localparam int CAP_AW  = 1 + SLOT_W + GRP_W;

   localparam logic [15:0] NO_POS    = 16'hFFFF;
   localparam logic [15:0] POS_LIMIT = 16'hFFFE;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef enum logic [3:0] {
      K_AS     = 4'd0,
      K_NOT_AS = 4'd1,
      K_ANY    = 4'd2,
      K_BEGIN  = 4'd3,
      K_END    = 4'd4,
      K_OPEN   = 4'd5,
      K_CLOSE  = 4'd6,
      K_ALT    = 4'd7,
      K_NOP    = 4'd8,
      K_STOP   = 4'd9
   } kind_type;

   typedef struct packed {
      logic [3:0]       kind;
      logic [IDX_W-1:0] next_idx;
      logic [IDX_W-1:0] alt_idx;
      logic [2:0]       group;
      logic [31:0]      asn;
   } prog_entry_type;

   typedef struct packed {
      logic [15:0] start_pos;
      logic [15:0] end_pos;
   } cap_type;

   typedef struct packed {
      logic                         we;
      logic [IDX_W-1:0]             waddr;
      prog_entry_type               wdata;
      logic [IDX_W-1:0]             raddr;
   } prog_req_type;

   typedef struct packed {
      logic              pc_we;
      logic [PC_AW-1:0]  pc_waddr;
      logic [IDX_W-1:0]  pc_wdata;
      logic [PC_AW-1:0]  pc_raddr;
      logic              cap_we;
      logic [CAP_AW-1:0] cap_waddr;
      cap_type           cap_wdata;
      logic [CAP_AW-1:0] cap_raddr;
   } thr_req_type;

endpackage
`default_nettype wire

### rtl/core/anpm_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying load and symbol transactions.
// ----------------------------------------------------------------------------
interface anpm_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [5:0]  instr_index;
   logic [3:0]  instr_type;
   logic [5:0]  next_index;
   logic [5:0]  alt_index;
   logic [2:0]  group_number;
   logic [31:0] asn_value;
   logic        symbol_first;
   logic        symbol_end;

   modport source (output valid, op, instr_index, instr_type, next_index, alt_index,
                   group_number, asn_value, symbol_first, symbol_end, input ready);
   modport sink (input valid, op, instr_index, instr_type, next_index, alt_index,
                 group_number, asn_value, symbol_first, symbol_end, output ready);
endinterface
`default_nettype wire

### rtl/core/anpm_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying group record transactions.
// ----------------------------------------------------------------------------
interface anpm_rsp_if;
   logic        valid;
   logic        ready;
   logic        matched;
   logic [2:0]  group_id;
   logic [15:0] group_start;
   logic [15:0] group_end;
   logic        error;
   logic        last;

   modport source (output valid, matched, group_id, group_start, group_end, error, last,
                   input ready);
   modport sink (input valid, matched, group_id, group_start, group_end, error, last,
                 output ready);
endinterface
`default_nettype wire

### rtl/core/asn_path_nfa_matcher_unit.sv
// A load transaction writes one program entry when accepted. For a symbol, each live
// thread first loads its program counter and capture words, then fetches and runs each
// instruction of its epsilon chain; each thread add scans the target list and writes 8
// capture words (one memory write port). Only one symbol is in flight at a time.
// The end symbol then gives 1 to 8 records, one per cycle when taken at once.
// Reset: synchronous, clears lists, kept match, position and start_index; program not cleared.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AS-path NFA matcher
// Top level: register port, program store, thread store and matcher engine.
// ----------------------------------------------------------------------------
module asn_path_nfa_matcher_unit
   import anpm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   anpm_req_if.sink         req_chan,
   anpm_rsp_if.source       rsp_chan,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [5:0]       start_index_ff;
   prog_req_type     prog_req;
   prog_entry_type   prog_rdata;
   thr_req_type      thr_req;
   logic [IDX_W-1:0] pc_rdata;
   cap_type          cap_rdata;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {26'd0, start_index_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_index_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == 1'b0)) begin
         start_index_ff <= csr_pwdata[5:0];
      end
   end

   anpm_prog_store u_prog_store (
      .clock      (clock),
      .prog_req   (prog_req),
      .prog_rdata (prog_rdata)
   );

   anpm_thread_store u_thread_store (
      .clock     (clock),
      .thr_req   (thr_req),
      .pc_rdata  (pc_rdata),
      .cap_rdata (cap_rdata)
   );

   anpm_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .start_index (start_index_ff),
      .prog_req    (prog_req),
      .prog_rdata  (prog_rdata),
      .thr_req     (thr_req),
      .pc_rdata    (pc_rdata),
      .cap_rdata   (cap_rdata)
   );

endmodule
`default_nettype wire

### rtl/core/anpm_prog_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Program store
// Single-port-write, registered-read memory of compiled instructions.
// ----------------------------------------------------------------------------
module anpm_prog_store
   import anpm_pkg::*;
(
   input  wire logic         clock,
   input  wire prog_req_type prog_req,
   output prog_entry_type    prog_rdata
);

   prog_entry_type mem [PROGRAM_DEPTH];

   always_ff @(posedge clock) begin
      if (prog_req.we) begin
         mem[prog_req.waddr] <= prog_req.wdata;
      end
      prog_rdata <= mem[prog_req.raddr];
   end

endmodule
`default_nettype wire

### rtl/core/anpm_thread_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Thread store
// Program counters and capture words of both thread lists, registered reads.
// ----------------------------------------------------------------------------
module anpm_thread_store
   import anpm_pkg::*;
(
   input  wire logic        clock,
   input  wire thr_req_type thr_req,
   output logic [IDX_W-1:0] pc_rdata,
   output cap_type          cap_rdata
);

   logic [IDX_W-1:0] pc_mem  [2 * THREAD_LIST];
   cap_type          cap_mem [2 * THREAD_LIST * MAX_GROUPS];

   always_ff @(posedge clock) begin
      if (thr_req.pc_we) begin
         pc_mem[thr_req.pc_waddr] <= thr_req.pc_wdata;
      end
      pc_rdata <= pc_mem[thr_req.pc_raddr];
   end

   always_ff @(posedge clock) begin
      if (thr_req.cap_we) begin
         cap_mem[thr_req.cap_waddr] <= thr_req.cap_wdata;
      end
      cap_rdata <= cap_mem[thr_req.cap_raddr];
   end

endmodule
`default_nettype wire

### rtl/core/anpm_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matcher engine
// Sequencer walking the thread lists and epsilon chains, plus record output.
// ----------------------------------------------------------------------------
module anpm_engine
   import anpm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   anpm_req_if.sink        req_chan,
   anpm_rsp_if.source      rsp_chan,
   input  wire logic [5:0] start_index,
   output prog_req_type    prog_req,
   input  prog_entry_type  prog_rdata,
   output thr_req_type     thr_req,
   input  wire logic [IDX_W-1:0] pc_rdata,
   input  cap_type         cap_rdata
);

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_START    = 11'b000_0000_0010,
      ST_ADD_SCAN = 11'b000_0000_0100,
      ST_ADD_CMP  = 11'b000_0000_1000,
      ST_ADD_WR   = 11'b000_0001_0000,
      ST_RUN_NEXT = 11'b000_0010_0000,
      ST_LOAD     = 11'b000_0100_0000,
      ST_FETCH    = 11'b000_1000_0000,
      ST_EXEC     = 11'b001_0000_0000,
      ST_FINISH   = 11'b010_0000_0000,
      ST_EMIT     = 11'b100_0000_0000
   } state_type;

   typedef enum logic [1:0] {
      RET_RUN    = 2'd0,
      RET_DONE   = 2'd1,
      RET_FOLLOW = 2'd2
   } ret_type;

   state_type        state_ff;
   ret_type          ret_ff;
   logic             ovf_ff;
   logic [CNT_W-1:0] cnt_ff [2];
   logic             lsel_ff;
   cap_type          best_ff [MAX_GROUPS];
   cap_type          work_ff [MAX_GROUPS];
   logic [15:0]      mcount_ff;
   logic [15:0]      pos_ff;
   logic [31:0]      sym_ff;
   logic             first_ff;
   logic             end_ff;
   logic [CNT_W-1:0] i_ff;
   logic [CNT_W-1:0] j_ff;
   logic [GK_W-1:0]  k_ff;
   logic [CHAIN_W-1:0] n_ff;
   logic [IDX_W-1:0] pc_ff;
   logic [IDX_W-1:0] follow_pc_ff;
   logic             add_list_ff;
   logic [IDX_W-1:0] add_pc_ff;
   logic [SLOT_W-1:0] add_slot_ff;
   logic             add_append_ff;
   logic [GRP_W-1:0] emit_ff;

   logic             rsp_valid_ff;
   logic             rsp_matched_ff;
   logic [2:0]       rsp_group_id_ff;
   logic [15:0]      rsp_group_start_ff;
   logic [15:0]      rsp_group_end_ff;
   logic             rsp_error_ff;
   logic             rsp_last_ff;

   logic cl, nl;
   logic req_accept;
   logic consume_ok;
   logic x_add, x_list, x_follow;
   logic [IDX_W-1:0] x_pc;
   ret_type x_ret;
   logic finish_add, follow_go, thread_done, chain_more, clear_path;
   logic [IDX_W-1:0] follow_target;
   logic emit_load;
   logic rec_matched, rec_error, rec_last;
   logic [15:0] rec_start, rec_end;
   logic [GRP_W-1:0] g;
   logic [GRP_W-1:0] emit_nx;
   logic pc_hit, cap_better;

   assign cl         = lsel_ff;
   assign nl         = ~lsel_ff;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept = req_chan.valid && (state_ff == ST_IDLE);
   assign g          = prog_rdata.group[GRP_W-1:0];

   // Instruction decode for the execute step
   always_comb begin
      consume_ok = 1'b0;
      x_add      = 1'b0;
      x_list     = nl;
      x_pc       = prog_rdata.next_idx;
      x_ret      = RET_DONE;
      x_follow   = 1'b0;
      case (prog_rdata.kind) inside
         K_AS:     consume_ok = !end_ff && (prog_rdata.asn == sym_ff);
         K_NOT_AS: consume_ok = !end_ff && (prog_rdata.asn != sym_ff);
         K_ANY:    consume_ok = !end_ff;
         default:  consume_ok = 1'b0;
      endcase
      case (prog_rdata.kind) inside
         K_AS, K_NOT_AS, K_ANY: x_add = consume_ok;
         K_BEGIN:               x_follow = first_ff;
         K_END:                 x_follow = end_ff;
         K_OPEN, K_CLOSE, K_NOP: x_follow = 1'b1;
         K_ALT: begin
            x_add  = 1'b1;
            x_list = cl;
            x_pc   = prog_rdata.alt_idx;
            x_ret  = RET_FOLLOW;
         end
         default: x_follow = 1'b0;
      endcase
   end

   assign pc_hit     = (pc_rdata == add_pc_ff);
   assign cap_better = (work_ff[0].start_pos < cap_rdata.start_pos);
   assign finish_add = ((state_ff == ST_ADD_CMP) && pc_hit && !cap_better) ||
                       ((state_ff == ST_ADD_WR) && (k_ff == GK_W'(MAX_GROUPS - 1)));
   assign follow_go  = ((state_ff == ST_EXEC) && !x_add && x_follow) ||
                       (finish_add && (ret_ff == RET_FOLLOW));
   assign follow_target = (state_ff == ST_EXEC) ? prog_rdata.next_idx : follow_pc_ff;
   assign chain_more = (CHAIN_W'(n_ff + 1'b1) < CHAIN_W'(CHAIN_LIMIT));
   assign thread_done = ((state_ff == ST_EXEC) && !x_add && !x_follow) ||
                        (finish_add && (ret_ff == RET_DONE)) ||
                        (follow_go && !chain_more);

   // Record selection for the end of a path
   assign emit_nx = GRP_W'(emit_ff + 1'b1);
   always_comb begin
      rec_matched = 1'b0;
      rec_start   = NO_POS;
      rec_end     = 16'd0;
      rec_error   = 1'b0;
      rec_last    = 1'b1;
      if (ovf_ff) begin
         rec_error = 1'b1;
      end else if (mcount_ff != 16'd0) begin
         rec_matched = 1'b1;
         rec_start   = best_ff[emit_ff].start_pos;
         rec_end     = best_ff[emit_ff].end_pos;
         rec_last    = (emit_ff == GRP_W'(NUM_RECORDS - 1)) ||
                       (best_ff[emit_nx].start_pos == NO_POS);
      end
   end

   assign emit_load  = !rsp_valid_ff || rsp_chan.ready;
   assign clear_path = (req_accept && req_chan.op && req_chan.symbol_first) ||
                       ((state_ff == ST_EMIT) && emit_load && rec_last);

   // Memory requests
   always_comb begin
      prog_req.we             = req_accept && !req_chan.op;
      prog_req.waddr          = req_chan.instr_index;
      prog_req.wdata.kind     = req_chan.instr_type;
      prog_req.wdata.next_idx = req_chan.next_index;
      prog_req.wdata.alt_idx  = req_chan.alt_index;
      prog_req.wdata.group    = req_chan.group_number;
      prog_req.wdata.asn      = req_chan.asn_value;
      prog_req.raddr          = pc_ff;

      thr_req.pc_we     = (state_ff == ST_ADD_WR) && (k_ff == '0) && add_append_ff;
      thr_req.pc_waddr  = {add_list_ff, add_slot_ff};
      thr_req.pc_wdata  = add_pc_ff;
      thr_req.cap_we    = (state_ff == ST_ADD_WR);
      thr_req.cap_waddr = {add_list_ff, add_slot_ff, k_ff[GRP_W-1:0]};
      thr_req.cap_wdata = work_ff[k_ff[GRP_W-1:0]];
      if (state_ff == ST_EXEC) begin
         // write the new whole-match start back so later merges compare against it
         thr_req.cap_we    = (prog_rdata.kind == K_OPEN) && (g == '0);
         thr_req.cap_waddr = {cl, i_ff[SLOT_W-1:0], GRP_W'(0)};
         thr_req.cap_wdata = '{start_pos: pos_ff, end_pos: work_ff[0].end_pos};
      end
      if (state_ff == ST_LOAD) begin
         thr_req.pc_raddr  = {cl, i_ff[SLOT_W-1:0]};
         thr_req.cap_raddr = {cl, i_ff[SLOT_W-1:0], k_ff[GRP_W-1:0]};
      end else begin
         thr_req.pc_raddr  = {add_list_ff, j_ff[SLOT_W-1:0]};
         thr_req.cap_raddr = {add_list_ff, j_ff[SLOT_W-1:0], GRP_W'(0)};
      end
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ret_ff        <= RET_RUN;
         ovf_ff        <= 1'b0;
         cnt_ff[0]     <= '0;
         cnt_ff[1]     <= '0;
         lsel_ff       <= 1'b0;
         for (int b = 0; b < MAX_GROUPS; b++) begin
            best_ff[b] <= '0;
         end
         best_ff[0]    <= '{start_pos: NO_POS, end_pos: 16'd0};
         mcount_ff     <= '0;
         pos_ff        <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         k_ff          <= '0;
         n_ff          <= '0;
         pc_ff         <= '0;
         add_append_ff <= 1'b0;
         emit_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept && req_chan.op) begin
                  sym_ff   <= req_chan.asn_value;
                  first_ff <= req_chan.symbol_first;
                  end_ff   <= req_chan.symbol_end;
                  state_ff <= ST_START;
               end
            end
            ST_START: begin
               if (ovf_ff) begin
                  state_ff <= end_ff ? ST_EMIT : ST_IDLE;
               end else begin
                  cnt_ff[nl] <= '0;
                  i_ff       <= '0;
                  if (mcount_ff == 16'd0) begin
                     add_list_ff <= cl;
                     add_pc_ff   <= start_index;
                     ret_ff      <= RET_RUN;
                     j_ff        <= '0;
                     state_ff    <= ST_ADD_SCAN;
                  end else begin
                     state_ff <= ST_RUN_NEXT;
                  end
               end
            end
            ST_ADD_SCAN: begin
               if (j_ff < cnt_ff[add_list_ff]) begin
                  state_ff <= ST_ADD_CMP;
               end else if (cnt_ff[add_list_ff] >= CNT_W'(THREAD_LIST)) begin
                  ovf_ff   <= 1'b1;
                  state_ff <= ST_FINISH;
               end else begin
                  add_slot_ff   <= cnt_ff[add_list_ff][SLOT_W-1:0];
                  add_append_ff <= 1'b1;
                  k_ff          <= '0;
                  state_ff      <= ST_ADD_WR;
               end
            end
            ST_ADD_CMP: begin
               if (pc_hit) begin
                  if (cap_better) begin
                     add_slot_ff   <= j_ff[SLOT_W-1:0];
                     add_append_ff <= 1'b0;
                     k_ff          <= '0;
                     state_ff      <= ST_ADD_WR;
                  end
               end else begin
                  j_ff     <= CNT_W'(j_ff + 1'b1);
                  state_ff <= ST_ADD_SCAN;
               end
            end
            ST_ADD_WR: begin
               if ((k_ff == '0) && add_append_ff) begin
                  cnt_ff[add_list_ff] <= CNT_W'(cnt_ff[add_list_ff] + 1'b1);
               end
               k_ff <= GK_W'(k_ff + 1'b1);
            end
            ST_RUN_NEXT: begin
               if (i_ff < cnt_ff[cl]) begin
                  k_ff     <= '0;
                  state_ff <= ST_LOAD;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_LOAD: begin
               if (k_ff == GK_W'(MAX_GROUPS)) begin
                  pc_ff    <= pc_rdata;
                  n_ff     <= '0;
                  state_ff <= ST_FETCH;
               end else begin
                  k_ff <= GK_W'(k_ff + 1'b1);
               end
            end
            ST_FETCH: begin
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               follow_pc_ff <= prog_rdata.next_idx;
               if (prog_rdata.kind == K_STOP) begin
                  // keep leftmost, then longest
                  if ((mcount_ff == 16'd0) ||
                      (work_ff[0].start_pos < best_ff[0].start_pos) ||
                      ((work_ff[0].start_pos == best_ff[0].start_pos) &&
                       (pos_ff > best_ff[0].end_pos))) begin
                     for (int b = 1; b < MAX_GROUPS; b++) begin
                        best_ff[b] <= work_ff[b];
                     end
                     best_ff[0] <= '{start_pos: work_ff[0].start_pos, end_pos: pos_ff};
                  end
                  if (mcount_ff != COUNT_MAX) begin
                     mcount_ff <= mcount_ff + 16'd1;
                  end
               end
               if (x_add) begin
                  add_list_ff <= x_list;
                  add_pc_ff   <= x_pc;
                  ret_ff      <= x_ret;
                  j_ff        <= '0;
                  state_ff    <= ST_ADD_SCAN;
               end
            end
            ST_FINISH: begin
               if (!ovf_ff) begin
                  lsel_ff <= nl;
               end
               if (pos_ff < POS_LIMIT) begin
                  pos_ff <= pos_ff + 16'd1;
               end
               state_ff <= end_ff ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
               if (emit_load) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_matched_ff     <= rec_matched;
                  rsp_group_id_ff    <= emit_ff;
                  rsp_group_start_ff <= rec_start;
                  rsp_group_end_ff   <= rec_end;
                  rsp_error_ff       <= rec_error;
                  rsp_last_ff        <= rec_last;
                  if (rec_last) begin
                     emit_ff  <= '0;
                     state_ff <= ST_IDLE;
                  end else begin
                     emit_ff <= emit_nx;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         // Common exits of the add routine and the chain walk
         if (finish_add && (ret_ff == RET_RUN)) begin
            state_ff <= ST_RUN_NEXT;
         end
         if (follow_go && chain_more) begin
            n_ff     <= CHAIN_W'(n_ff + 1'b1);
            pc_ff    <= follow_target;
            state_ff <= ST_FETCH;
         end
         if (thread_done) begin
            i_ff     <= CNT_W'(i_ff + 1'b1);
            state_ff <= ST_RUN_NEXT;
         end

         if (clear_path) begin
            cnt_ff[0] <= '0;
            cnt_ff[1] <= '0;
            lsel_ff   <= 1'b0;
            for (int b = 0; b < MAX_GROUPS; b++) begin
               best_ff[b] <= '0;
            end
            best_ff[0] <= '{start_pos: NO_POS, end_pos: 16'd0};
            mcount_ff  <= '0;
            pos_ff     <= '0;
            ovf_ff     <= 1'b0;
         end
      end
   end

   // Working capture vector of the thread in flight
   always_ff @(posedge clock) begin
      if ((state_ff == ST_START) && !ovf_ff && (mcount_ff == 16'd0)) begin
         for (int b = 0; b < MAX_GROUPS; b++) begin
            work_ff[b] <= '0;
         end
         work_ff[0] <= '{start_pos: pos_ff, end_pos: 16'd0};
         work_ff[1] <= '{start_pos: NO_POS, end_pos: 16'd0};
      end else if ((state_ff == ST_LOAD) && (k_ff != '0)) begin
         work_ff[GRP_W'(k_ff - 1'b1)] <= cap_rdata;
      end else if (state_ff == ST_EXEC) begin
         case (prog_rdata.kind) inside
            K_OPEN: begin
               work_ff[g].start_pos <= pos_ff;
               if (g != GRP_W'(MAX_GROUPS - 1)) begin
                  work_ff[GRP_W'(g + 1'b1)] <= '{start_pos: NO_POS, end_pos: 16'd0};
               end
            end
            K_CLOSE: work_ff[g].end_pos <= pos_ff;
            K_STOP:  work_ff[0].end_pos <= pos_ff;
            default: ;
         endcase
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.matched     = rsp_matched_ff;
   assign rsp_chan.group_id    = rsp_group_id_ff;
   assign rsp_chan.group_start = rsp_group_start_ff;
   assign rsp_chan.group_end   = rsp_group_end_ff;
   assign rsp_chan.error       = rsp_error_ff;
   assign rsp_chan.last        = rsp_last_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff[0] <= CNT_W'(THREAD_LIST)) && (cnt_ff[1] <= CNT_W'(THREAD_LIST)))
      else $error("thread count beyond list size");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ADD_WR) && add_append_ff && (k_ff == '0)) |->
      (cnt_ff[add_list_ff] < CNT_W'(THREAD_LIST)))
      else $error("append into a full thread list");

   a_chain_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> (n_ff < CHAIN_W'(CHAIN_LIMIT)))
      else $error("epsilon chain ran past its limit");

   a_best_valid: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && !ovf_ff && (mcount_ff != 16'd0)) |->
      (best_ff[0].start_pos != NO_POS))
      else $error("match counted without a kept start");

endmodule
`default_nettype wire
